// ===== hdl/mtp_pkg.sv =====
// ----------------------------------------------------------------------------
// mtp_pkg
// Shared widths, constants and control types for the masonry tile placer.
// ----------------------------------------------------------------------------
package mtp_pkg;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;
  localparam int COUNT_CFG_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_LAYOUT_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_SPACING = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 2'd2;

  localparam int DEFAULT_MAX_COLUMNS = 8;

  // Input item fields
  localparam logic FUNC_PLACE = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;
  localparam int   PREVIEW_W  = 16;
  localparam int   IN_TDATA_W = 32;

  // Result item fields
  localparam int TILE_X_W         = 24;
  localparam int TILE_Y_W         = 32;
  localparam int TILE_WIDTH_W     = 24;
  localparam int TILE_HEIGHT_W    = 18;
  localparam int COLUMN_INDEX_W   = 3;
  localparam int CONTENT_HEIGHT_W = 32;
  localparam int OUT_TDATA_W      = 136;

  // Aspect ratio, Q16
  localparam int                 ASPECT_W   = 18;
  localparam logic [ASPECT_W-1:0] ASPECT_ONE = 18'd65536;
  localparam logic [ASPECT_W-1:0] ASPECT_MIN = 18'd29491;
  localparam logic [ASPECT_W-1:0] ASPECT_MAX = 18'd144179;

  typedef struct packed {
    logic capture;   // input beat taken this cycle
    logic prep;      // set up dividers and column scan
    logic step;      // one divider step / one scan read
    logic clamp;     // clamp aspect ratio
    logic mult;      // height and x products
    logic update;    // column bottom write-back or clear
    logic load_out;  // load the output register
  } mtp_cmd_t;

  typedef struct packed {
    logic work_done; // both dividers and the scan are finished
  } mtp_sts_t;

endpackage

// ===== hdl/mtp_divider.sv =====
// ----------------------------------------------------------------------------
// mtp_divider
// Restoring divider, one quotient bit per step.
// ----------------------------------------------------------------------------
module mtp_divider #(
  parameter int QUO_W = 24,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             step,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [QUO_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [QUO_W-1:0] num_sh;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic             active;

  assign trial  = {rem, num_sh[QUO_W-1]};
  assign fits   = trial >= {1'b0, den};
  assign diff   = trial - {1'b0, den};
  assign active = step && (cnt != '0);
  assign done   = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(QUO_W);
    end else if (active) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem    <= rem_init;
      num_sh <= num;
      quo    <= '0;
    end else if (active) begin
      rem    <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      num_sh <= {num_sh[QUO_W-2:0], 1'b0};
      quo    <= {quo[QUO_W-2:0], fits};
    end
  end

endmodule

// ===== hdl/mtp_datapath.sv =====
// ----------------------------------------------------------------------------
// mtp_datapath
// Config registers, dividers, column-bottom memory, scan and result math.
// ----------------------------------------------------------------------------
module mtp_datapath #(
  parameter int MAX_COLUMNS = mtp_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mtp_pkg::mtp_cmd_t                   cmd,
  output mtp_pkg::mtp_sts_t                   sts,
  input  logic                                cfg_wr_en,
  input  logic [mtp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [mtp_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  output logic [mtp_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int IDX_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
  localparam int GAP_W  = mtp_pkg::TILE_WIDTH_W + CNT_W;
  localparam int PROD_W = mtp_pkg::TILE_WIDTH_W + mtp_pkg::ASPECT_W;
  localparam int PITCH_W = mtp_pkg::TILE_WIDTH_W + 1;
  localparam int XP_W   = PITCH_W + IDX_W;
  localparam int NB_W   = mtp_pkg::TILE_Y_W + 2;
  localparam int PW     = mtp_pkg::PREVIEW_W;
  localparam int AW     = mtp_pkg::ASPECT_W;
  localparam int YW     = mtp_pkg::TILE_Y_W;
  localparam int HW     = mtp_pkg::TILE_HEIGHT_W;
  localparam int XW     = mtp_pkg::TILE_X_W;

  // config
  logic [mtp_pkg::CFG_DATA_W-1:0]  layout_width;
  logic [mtp_pkg::CFG_DATA_W-1:0]  tile_spacing;
  logic [CNT_W-1:0]                column_count;
  logic [mtp_pkg::COUNT_CFG_W-1:0] count_wr;
  logic [CNT_W-1:0]                count_clamped;
  logic                            layout_clear;

  // captured item
  logic          func_q;
  logic [PW-1:0] pw_q;
  logic [PW-1:0] ph_q;
  logic [GAP_W-1:0] gaps;
  logic          unit_aspect;
  logic          big_aspect;

  // dividers
  logic [mtp_pkg::TILE_WIDTH_W-1:0] cw_num;
  logic [mtp_pkg::TILE_WIDTH_W-1:0] col_width;
  logic [AW-1:0]                    asp_quo;
  logic                             cw_done;
  logic                             asp_done;

  // column memory and scan
  logic [YW-1:0]          bottoms [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] valid;
  logic [YW-1:0]          rd_data;
  logic                   rd_valid;
  logic [CNT_W-1:0]       scan_idx;
  logic                   scan_issue;
  logic                   pend;
  logic [IDX_W-1:0]       pend_addr;
  logic [YW-1:0]          cand;
  logic [YW-1:0]          best;
  logic [IDX_W-1:0]       best_col;
  logic [YW-1:0]          tallest;

  // result math
  logic [AW-1:0]     aspect;
  logic [AW-1:0]     aspect_next;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_rnd;
  logic [XP_W-1:0]   xprod;
  logic [HW-1:0]     res_h;
  logic [XW-1:0]     res_x;
  logic [NB_W-1:0]   nb;
  logic [YW-1:0]     nb_sat;
  logic [YW-1:0]     content;
  logic [31:0]       col_ext;

  // ---------------- configuration ----------------
  assign count_wr = cfg_data[mtp_pkg::COUNT_CFG_W-1:0];

  always_comb begin
    if (count_wr == '0) begin
      count_clamped = CNT_W'(1);
    end else if (32'(count_wr) > MAX_COLUMNS) begin
      count_clamped = CNT_W'(MAX_COLUMNS);
    end else begin
      count_clamped = CNT_W'(count_wr);
    end
  end

  assign layout_clear = (cfg_wr_en && (cfg_index == mtp_pkg::REG_COLUMN_COUNT)) ||
                        (cmd.update && (func_q == mtp_pkg::FUNC_CLEAR));

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_width <= '0;
      tile_spacing <= '0;
      column_count <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        mtp_pkg::REG_LAYOUT_WIDTH: layout_width <= cfg_data;
        mtp_pkg::REG_TILE_SPACING: tile_spacing <= cfg_data;
        mtp_pkg::REG_COLUMN_COUNT: column_count <= count_clamped;
        default: ;
      endcase
    end
  end

  // ---------------- capture and setup ----------------
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= in_tuser;
      pw_q   <= in_tdata[PW-1:0];
      ph_q   <= in_tdata[2*PW-1:PW];
      gaps   <= GAP_W'(tile_spacing) * GAP_W'(column_count - 1'b1);
    end
    if (cmd.prep) begin
      unit_aspect <= (pw_q == '0) || (ph_q == '0);
      big_aspect  <= {2'b00, ph_q} >= {pw_q, 2'b00};
    end
  end

  always_comb begin
    if (GAP_W'(layout_width) > gaps) begin
      cw_num = mtp_pkg::TILE_WIDTH_W'(GAP_W'(layout_width) - gaps);
    end else begin
      cw_num = '0;
    end
  end

  mtp_divider #(
    .QUO_W (mtp_pkg::TILE_WIDTH_W),
    .DEN_W (CNT_W)
  ) u_cw_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.prep),
    .step     (cmd.step),
    .rem_init ('0),
    .num      (cw_num),
    .den      (column_count),
    .quo      (col_width),
    .done     (cw_done)
  );

  // ph<<16 / pw; the top 14 numerator bits seed the remainder, since any
  // quotient of 2^18 or more is clamped away anyway
  mtp_divider #(
    .QUO_W (AW),
    .DEN_W (PW)
  ) u_asp_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.prep),
    .step     (cmd.step),
    .rem_init ({2'b00, ph_q[PW-1:2]}),
    .num      ({ph_q[1:0], 16'd0}),
    .den      (pw_q),
    .quo      (asp_quo),
    .done     (asp_done)
  );

  // ---------------- column scan ----------------
  assign scan_issue = cmd.step && (scan_idx != column_count);
  assign cand       = rd_valid ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx <= '0;
      pend     <= 1'b0;
    end else if (cmd.prep) begin
      scan_idx <= '0;
      pend     <= 1'b0;
    end else if (cmd.step) begin
      pend <= scan_issue;
      if (scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) begin
      pend_addr <= scan_idx[IDX_W-1:0];
    end
    if (cmd.step && pend) begin
      if ((pend_addr == '0) || (cand < best)) begin
        best     <= cand;
        best_col <= pend_addr;
      end
    end
  end

  assign sts.work_done = cw_done && asp_done && (scan_idx == column_count) && !pend;

  // bottom memory: read during scan, written on a place update
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_data <= bottoms[scan_idx[IDX_W-1:0]];
    end
    if (cmd.update && (func_q == mtp_pkg::FUNC_PLACE)) begin
      bottoms[best_col] <= nb_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
      tallest  <= '0;
    end else begin
      if (scan_issue) begin
        rd_valid <= valid[scan_idx[IDX_W-1:0]];
      end
      if (layout_clear) begin
        valid   <= '0;
        tallest <= '0;
      end else if (cmd.update) begin
        valid[best_col] <= 1'b1;
        if (nb_sat > tallest) begin
          tallest <= nb_sat;
        end
      end
    end
  end

  // ---------------- result math ----------------
  always_comb begin
    if (unit_aspect) begin
      aspect_next = mtp_pkg::ASPECT_ONE;
    end else if (big_aspect || (asp_quo > mtp_pkg::ASPECT_MAX)) begin
      aspect_next = mtp_pkg::ASPECT_MAX;
    end else if (asp_quo < mtp_pkg::ASPECT_MIN) begin
      aspect_next = mtp_pkg::ASPECT_MIN;
    end else begin
      aspect_next = asp_quo;
    end
  end

  assign prod_rnd = prod + PROD_W'(1 << 23);
  assign nb       = NB_W'(best) + NB_W'({prod_rnd[PROD_W-1:24], 8'd0}) +
                    NB_W'(tile_spacing);
  assign nb_sat   = (nb[NB_W-1:YW] != '0) ? '1 : nb[YW-1:0];
  assign content  = (tallest > YW'(tile_spacing)) ? (tallest - YW'(tile_spacing)) : '0;
  assign col_ext  = 32'(best_col);

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      aspect <= aspect_next;
    end
    if (cmd.mult) begin
      prod  <= PROD_W'(col_width) * PROD_W'(aspect);
      xprod <= XP_W'(best_col) * XP_W'(PITCH_W'(col_width) + PITCH_W'(tile_spacing));
    end
    if (cmd.update) begin
      res_h <= prod_rnd[PROD_W-1:24];
      res_x <= (xprod > XP_W'({XW{1'b1}})) ? '1 : xprod[XW-1:0];
    end
    if (cmd.load_out) begin
      if (func_q == mtp_pkg::FUNC_CLEAR) begin
        out_tdata <= {3'd0, 32'd0, 3'd0, 18'd0, col_width, 32'd0, 24'd0};
      end else begin
        out_tdata <= {3'd0, content, col_ext[mtp_pkg::COLUMN_INDEX_W-1:0], res_h,
                      col_width, best, res_x};
      end
    end
  end

endmodule

// ===== hdl/mtp_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtp_ctrl
// Sequencer: one item at a time through setup, iterate, math and output.
// ----------------------------------------------------------------------------
module mtp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mtp_pkg::mtp_sts_t sts,
  output mtp_pkg::mtp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_WORK,
    ST_CLAMP,
    ST_MULT,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.prep     = (state == ST_PREP);
    cmd.step     = (state == ST_WORK);
    cmd.clamp    = (state == ST_CLAMP);
    cmd.mult     = (state == ST_MULT);
    cmd.update   = (state == ST_UPDATE);
    cmd.load_out = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      // a load refills the output register in the cycle it drains
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_ready && in_valid) begin
            state    <= ST_PREP;
            in_ready <= 1'b0;
          end
        end
        ST_PREP:   state <= ST_WORK;
        ST_WORK: begin
          if (sts.work_done) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP:  state <= ST_MULT;
        ST_MULT:   state <= ST_UPDATE;
        ST_UPDATE: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            in_ready  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/masonry_tile_placer.sv =====
// ----------------------------------------------------------------------------
// masonry_tile_placer
// Masonry layout: puts each tile in the lowest column and sizes it from the
// source aspect ratio; reports tile geometry and total content height.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tdata {preview_height, preview_width},
//                                     tuser func (0 place, 1 clear)
// m_*       out  m_tvalid/m_tready    tdata {content_height, column_index,
//                                     tile_height, tile_width, tile_y, tile_x}
// cfg_*     in   cfg_wr_en            cfg_index selects register, cfg_data
//
// Work: the 24-step column-width divider, the aspect divider (18 steps) and
//   the column scan (one bottom-memory read per cycle) run side by side; a
//   new item is taken only after the last one is loaded for output.
// Reset (rst, synchronous): registers to layout_width 0, tile_spacing 0,
//   column_count 1; all columns empty. No clearing pass.
// Stalls: the result sits in the output register; the next beat is taken
//   while it waits, and the sequencer holds at its last step if the output
//   register is still full.
// ----------------------------------------------------------------------------
module masonry_tile_placer #(
  parameter int MAX_COLUMNS = mtp_pkg::DEFAULT_MAX_COLUMNS
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write port
  input  logic                            cfg_wr_en,
  input  logic [mtp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mtp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [mtp_pkg::IN_TDATA_W-1:0]  s_tdata,  // [15:0] preview_width,
                                                    // [31:16] preview_height
  input  logic                            s_tuser,  // [0] func
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mtp_pkg::OUT_TDATA_W-1:0] m_tdata   // [23:0] tile_x,
                                                    // [55:24] tile_y,
                                                    // [79:56] tile_width,
                                                    // [97:80] tile_height,
                                                    // [100:98] column_index,
                                                    // [132:101] content_height,
                                                    // [135:133] zero
);

  mtp_pkg::mtp_cmd_t cmd;
  mtp_pkg::mtp_sts_t sts;

  // sequencer: owns both handshakes
  mtp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: config regs, dividers, column memory, output register
  mtp_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (s_tdata),
    .in_tuser  (s_tuser),
    .out_tdata (m_tdata)
  );

  // one item in flight: a taken beat closes the input until its result is loaded into the output register
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in flight");

  // a new result appears only where the sequencer loads the output register
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.load_out))
    else $error("result valid without an output load");

  // the output register is never overwritten while a result is held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!m_tvalid || m_tready))
    else $error("output register loaded while full");

endmodule
